// ===== design/mpw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mpw_pkg: shared types and constants for the max pooling window block
// Register indexes, line store geometry, the clamped configuration and the
// job record that travels from the front classifier to the back engine.
// ---------------------------------------------------------------------------
package mpw_pkg;

   // line store geometry: columns per row and rows kept in the ring
   localparam int MAX_COLS = 64;
   localparam int MAX_WIN  = 8;

   // register indexes on the csr port
   localparam logic [2:0] REG_MAP_ROWS      = 3'd0;
   localparam logic [2:0] REG_MAP_COLS      = 3'd1;
   localparam logic [2:0] REG_WIN_ROWS      = 3'd2;
   localparam logic [2:0] REG_WIN_COLS      = 3'd3;
   localparam logic [2:0] REG_STEP_ROWS     = 3'd4;
   localparam logic [2:0] REG_STEP_COLS     = 3'd5;
   localparam logic [2:0] REG_CHANNEL_COUNT = 3'd6;

   // configuration after clamping of zero and oversize values
   typedef struct packed {
      logic [10:0] rows;
      logic [6:0]  cols;
      logic [3:0]  wr;
      logic [3:0]  wc;
      logic [3:0]  sr;
      logic [3:0]  sc;
      logic [8:0]  chans;
   } cfg_type;

   // one classified sample: position, ring slots and lowest window starts
   typedef struct packed {
      logic signed [15:0] sample;
      logic [7:0]  channel;
      logic [9:0]  r;
      logic [6:0]  c;
      logic [3:0]  slot_r;
      logic [9:0]  rlo;
      logic [9:0]  rlo_q;
      logic [3:0]  rlo_m;
      logic [3:0]  rlo_slot;
      logic [6:0]  clo;
      logic [6:0]  clo_q;
      logic [3:0]  clo_m;
      logic        r_last;
      logic        c_last;
   } job_type;

endpackage
`default_nettype wire

// ===== design/max_pooling_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// max_pooling_window: 2-D max pooling over raster-order feature maps
// Configuration registers, front classifier, job queue and pooling engine.
//
//   channel  signals                               direction
//   req      req_valid/req_ready, req_sample       in, one sample per transfer
//   rsp      rsp_valid/rsp_ready, rsp_*            out, one window maximum
//   csr      csr_valid/csr_ready, csr_index/data   in, register write
//
// Per sample: the sample is stored, then each candidate window start
// (rows r_lo..r times columns c_lo..c) is evaluated, each completed
// h x w window is scanned through the single-port line store, and the
// held result is released. Default pooling is 2x2 with step 2.
// Reset is synchronous; line store contents are not cleared.
// A stalled rsp backs up into the two-entry queue, then req_ready drops.
// ---------------------------------------------------------------------------
module max_pooling_window
   import mpw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic signed [15:0] req_sample,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [15:0] rsp_pooled_value,
   output logic [7:0]       rsp_channel,
   output logic [9:0]       rsp_out_row,
   output logic [5:0]       rsp_out_col,
   output logic             rsp_last_in_run,
   output logic             rsp_last_of_map,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   logic [10:0] map_rows_ff;
   logic [6:0]  map_cols_ff;
   logic [3:0]  win_rows_ff, win_cols_ff, step_rows_ff, step_cols_ff;
   logic [8:0]  channel_count_ff;
   logic        csr_write, restart;
   cfg_type     cfg;
   job_type     push_job, pop_job;
   logic        q_push, q_pop, q_full, q_empty;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign restart   = csr_write && (csr_index <= REG_CHANNEL_COUNT);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_rows_ff      <= 11'd24;
         map_cols_ff      <= 7'd24;
         win_rows_ff      <= 4'd2;
         win_cols_ff      <= 4'd2;
         step_rows_ff     <= 4'd2;
         step_cols_ff     <= 4'd2;
         channel_count_ff <= 9'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MAP_ROWS:      map_rows_ff      <= csr_data[10:0];
            REG_MAP_COLS:      map_cols_ff      <= csr_data[6:0];
            REG_WIN_ROWS:      win_rows_ff      <= csr_data[3:0];
            REG_WIN_COLS:      win_cols_ff      <= csr_data[3:0];
            REG_STEP_ROWS:     step_rows_ff     <= csr_data[3:0];
            REG_STEP_COLS:     step_cols_ff     <= csr_data[3:0];
            REG_CHANNEL_COUNT: channel_count_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // clamp zero and oversize settings
   always_comb begin
      cfg.rows  = (map_rows_ff == '0) ? 11'd1 :
                  (map_rows_ff > 11'd1024) ? 11'd1024 : map_rows_ff;
      cfg.cols  = (map_cols_ff == '0) ? 7'd1 :
                  (32'(map_cols_ff) > MAX_COLS) ? 7'(MAX_COLS) : map_cols_ff;
      cfg.wr    = (win_rows_ff == '0) ? 4'd1 :
                  (32'(win_rows_ff) > MAX_WIN) ? 4'(MAX_WIN) : win_rows_ff;
      cfg.wc    = (win_cols_ff == '0) ? 4'd1 :
                  (32'(win_cols_ff) > MAX_WIN) ? 4'(MAX_WIN) : win_cols_ff;
      cfg.sr    = (step_rows_ff == '0) ? 4'd1 : step_rows_ff;
      cfg.sc    = (step_cols_ff == '0) ? 4'd1 : step_cols_ff;
      cfg.chans = (channel_count_ff == '0) ? 9'd1 :
                  (channel_count_ff > 9'd256) ? 9'd256 : channel_count_ff;
   end

   mpw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .restart    (restart),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   mpw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   mpw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_empty          (q_empty),
      .q_job            (pop_job),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pooled_value (rsp_pooled_value),
      .rsp_channel      (rsp_channel),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_last_in_run  (rsp_last_in_run),
      .rsp_last_of_map  (rsp_last_of_map)
   );

   // the final window of a map is always the last result of its sample
   a_lom_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_map |-> rsp_last_in_run)
      else $error("last_of_map without last_in_run");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // the queue is never pushed while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job queue overflow");

endmodule
`default_nettype wire

// ===== design/mpw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mpw_front: raster position tracking and sample classification
// Tracks row, column and channel of the stream, plus the lowest window
// start that can still end at the current sample, with its quotient and
// remainder by the step kept as running counters.
// ---------------------------------------------------------------------------
module mpw_front
   import mpw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        restart,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_sample,
   input  wire logic        q_full,
   output logic             q_push,
   output job_type          q_job
);

   logic [9:0] r_ff, rlo_ff, rlo_q_ff;
   logic [6:0] c_ff, clo_ff, clo_q_ff;
   logic [3:0] slot_ff, rlo_slot_ff, rlo_m_ff, clo_m_ff;
   logic [7:0] ch_ff;
   logic       col_wrap, row_wrap, ch_wrap;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   assign col_wrap = ({1'b0, c_ff} + 8'd1) >= {1'b0, cfg.cols};
   assign row_wrap = ({1'b0, r_ff} + 11'd1) >= cfg.rows;
   assign ch_wrap  = ({1'b0, ch_ff} + 9'd1) >= cfg.chans;

   // job record for the current sample
   always_comb begin
      q_job          = '0;
      q_job.sample   = $signed(req_sample);
      q_job.channel  = ch_ff;
      q_job.r        = r_ff;
      q_job.c        = c_ff;
      q_job.slot_r   = slot_ff;
      q_job.rlo      = rlo_ff;
      q_job.rlo_q    = rlo_q_ff;
      q_job.rlo_m    = rlo_m_ff;
      q_job.rlo_slot = rlo_slot_ff;
      q_job.clo      = clo_ff;
      q_job.clo_q    = clo_q_ff;
      q_job.clo_m    = clo_m_ff;
      q_job.r_last   = ({1'b0, r_ff} + 11'd1) == cfg.rows;
      q_job.c_last   = ({1'b0, c_ff} + 8'd1) == {1'b0, cfg.cols};
   end

   // position counters, advanced on each input transfer
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         r_ff <= '0; rlo_ff <= '0; rlo_q_ff <= '0; rlo_m_ff <= '0;
         c_ff <= '0; clo_ff <= '0; clo_q_ff <= '0; clo_m_ff <= '0;
         slot_ff <= '0; rlo_slot_ff <= '0;
         if (reset) begin
            ch_ff <= '0;
         end
      end else if (q_push) begin
         if (col_wrap) begin
            c_ff <= '0; clo_ff <= '0; clo_q_ff <= '0; clo_m_ff <= '0;
            if (row_wrap) begin
               r_ff <= '0; rlo_ff <= '0; rlo_q_ff <= '0; rlo_m_ff <= '0;
               slot_ff <= '0; rlo_slot_ff <= '0;
               ch_ff <= ch_wrap ? 8'd0 : ch_ff + 8'd1;
            end else begin
               r_ff    <= r_ff + 10'd1;
               slot_ff <= ({1'b0, slot_ff} + 5'd1 == 5'(MAX_WIN)) ? 4'd0 : slot_ff + 4'd1;
               if (({1'b0, r_ff} + 11'd1) >= {7'd0, cfg.wr}) begin
                  rlo_ff      <= rlo_ff + 10'd1;
                  rlo_slot_ff <= ({1'b0, rlo_slot_ff} + 5'd1 == 5'(MAX_WIN)) ?
                                 4'd0 : rlo_slot_ff + 4'd1;
                  if (rlo_m_ff + 4'd1 == cfg.sr) begin
                     rlo_m_ff <= '0;
                     rlo_q_ff <= rlo_q_ff + 10'd1;
                  end else begin
                     rlo_m_ff <= rlo_m_ff + 4'd1;
                  end
               end
            end
         end else begin
            c_ff <= c_ff + 7'd1;
            if (({1'b0, c_ff} + 8'd1) >= {4'd0, cfg.wc}) begin
               clo_ff <= clo_ff + 7'd1;
               if (clo_m_ff + 4'd1 == cfg.sc) begin
                  clo_m_ff <= '0;
                  clo_q_ff <= clo_q_ff + 7'd1;
               end else begin
                  clo_m_ff <= clo_m_ff + 4'd1;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

// ===== design/mpw_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mpw_queue: two-entry job queue
// Decouples the classifier from the pooling engine.
// ---------------------------------------------------------------------------
module mpw_queue
   import mpw_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      pop_job,
   output logic         full,
   output logic         empty
);

   job_type    entry_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign pop_job = entry_ff[rptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_job;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop)  rptr_ff <= !rptr_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

endmodule
`default_nettype wire

// ===== design/mpw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mpw_back: line store and window maximum engine
// Writes each sample into a ring of map rows, walks the candidate window
// starts that may end at it, scans each complete window through the line
// store and emits its maximum. One result is held back so the last one of
// each sample can be flagged.
// ---------------------------------------------------------------------------
module mpw_back
   import mpw_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    q_empty,
   input  wire job_type q_job,
   output logic         q_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic signed [15:0] rsp_pooled_value,
   output logic [7:0]   rsp_channel,
   output logic [9:0]   rsp_out_row,
   output logic [5:0]   rsp_out_col,
   output logic         rsp_last_in_run,
   output logic         rsp_last_of_map
);

   localparam int DEPTH = MAX_WIN * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EVAL, ST_SCAN, ST_WAIT, ST_EMIT, ST_ADV, ST_FLUSH
   } state_type;

   state_type state_ff;
   job_type   job_ff;

   logic signed [15:0] mem [DEPTH];
   logic signed [15:0] rd_data_ff, best_ff;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          wr_en, rd_en, rd_pend_ff, first_ff;

   logic [9:0] r0_ff, r0_q_ff, rr_ff;
   logic [3:0] r0_m_ff, r0_slot_ff, rr_slot_ff;
   logic [6:0] c0_ff, c0_q_ff, cc_ff;
   logic [3:0] c0_m_ff;

   logic signed [15:0] hold_value_ff;
   logic [7:0]  hold_ch_ff;
   logic [9:0]  hold_row_ff;
   logic [5:0]  hold_col_ff;
   logic        hold_lom_ff, hold_valid_ff;

   logic row_ok, col_ok, out_free, lom, rsp_load;

   // line store access
   assign wr_en   = (state_ff == ST_IDLE) && !q_empty;
   assign q_pop   = wr_en;
   assign wr_addr = AW'(32'(q_job.slot_r) * MAX_COLS + 32'(q_job.c));
   assign rd_en   = state_ff == ST_SCAN;
   assign rd_addr = AW'(32'(rr_slot_ff) * MAX_COLS + 32'(cc_ff));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= q_job.sample;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // candidate window checks
   assign row_ok = (r0_m_ff == 4'd0) &&
                   (job_ff.r_last || ({1'b0, r0_ff} + {7'd0, cfg.wr} - 11'd1 == {1'b0, job_ff.r}));
   assign col_ok = (c0_m_ff == 4'd0) &&
                   (job_ff.c_last || ({1'b0, c0_ff} + {4'd0, cfg.wc} - 8'd1 == {1'b0, job_ff.c}));
   assign lom    = (({1'b0, r0_ff} + {7'd0, cfg.sr}) >= cfg.rows) &&
                   (({1'b0, c0_ff} + {4'd0, cfg.sc}) >= {1'b0, cfg.cols});
   assign out_free = !rsp_valid || rsp_ready;
   // held result moves to the output register this cycle
   assign rsp_load = ((state_ff == ST_EMIT) || (state_ff == ST_FLUSH)) &&
                     hold_valid_ff && out_free;

   // sequencer, accumulator and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid     <= 1'b0;
         rd_pend_ff    <= 1'b0;
      end else begin
         rd_pend_ff <= rd_en;
         if (rd_pend_ff) begin
            first_ff <= 1'b0;
            if (first_ff || (rd_data_ff > best_ff)) best_ff <= rd_data_ff;
         end
         if (rsp_load) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  job_ff     <= q_job;
                  r0_ff      <= q_job.rlo;
                  r0_q_ff    <= q_job.rlo_q;
                  r0_m_ff    <= q_job.rlo_m;
                  r0_slot_ff <= q_job.rlo_slot;
                  c0_ff      <= q_job.clo;
                  c0_q_ff    <= q_job.clo_q;
                  c0_m_ff    <= q_job.clo_m;
                  state_ff   <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               if (row_ok && col_ok) begin
                  rr_ff      <= r0_ff;
                  rr_slot_ff <= r0_slot_ff;
                  cc_ff      <= c0_ff;
                  first_ff   <= 1'b1;
                  state_ff   <= ST_SCAN;
               end else begin
                  state_ff <= ST_ADV;
               end
            end
            ST_SCAN: begin
               if (cc_ff == job_ff.c) begin
                  cc_ff      <= c0_ff;
                  rr_ff      <= rr_ff + 10'd1;
                  rr_slot_ff <= ({1'b0, rr_slot_ff} + 5'd1 == 5'(MAX_WIN)) ?
                                4'd0 : rr_slot_ff + 4'd1;
                  if (rr_ff == job_ff.r) state_ff <= ST_WAIT;
               end else begin
                  cc_ff <= cc_ff + 7'd1;
               end
            end
            ST_WAIT: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!hold_valid_ff || out_free) begin
                  if (hold_valid_ff) begin
                     rsp_pooled_value <= hold_value_ff;
                     rsp_channel      <= hold_ch_ff;
                     rsp_out_row      <= hold_row_ff;
                     rsp_out_col      <= hold_col_ff;
                     rsp_last_in_run  <= 1'b0;
                     rsp_last_of_map  <= hold_lom_ff;
                  end
                  hold_valid_ff <= 1'b1;
                  hold_value_ff <= best_ff;
                  hold_ch_ff    <= job_ff.channel;
                  hold_row_ff   <= r0_q_ff;
                  hold_col_ff   <= c0_q_ff[5:0];
                  hold_lom_ff   <= lom;
                  state_ff      <= ST_ADV;
               end
            end
            ST_ADV: begin
               if (c0_ff == job_ff.c) begin
                  if (r0_ff == job_ff.r) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     r0_ff      <= r0_ff + 10'd1;
                     r0_slot_ff <= ({1'b0, r0_slot_ff} + 5'd1 == 5'(MAX_WIN)) ?
                                   4'd0 : r0_slot_ff + 4'd1;
                     if (r0_m_ff + 4'd1 == cfg.sr) begin
                        r0_m_ff <= '0;
                        r0_q_ff <= r0_q_ff + 10'd1;
                     end else begin
                        r0_m_ff <= r0_m_ff + 4'd1;
                     end
                     c0_ff    <= job_ff.clo;
                     c0_q_ff  <= job_ff.clo_q;
                     c0_m_ff  <= job_ff.clo_m;
                     state_ff <= ST_EVAL;
                  end
               end else begin
                  c0_ff <= c0_ff + 7'd1;
                  if (c0_m_ff + 4'd1 == cfg.sc) begin
                     c0_m_ff <= '0;
                     c0_q_ff <= c0_q_ff + 7'd1;
                  end else begin
                     c0_m_ff <= c0_m_ff + 4'd1;
                  end
                  state_ff <= ST_EVAL;
               end
            end
            ST_FLUSH: begin
               if (!hold_valid_ff) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  rsp_pooled_value <= hold_value_ff;
                  rsp_channel      <= hold_ch_ff;
                  rsp_out_row      <= hold_row_ff;
                  rsp_out_col      <= hold_col_ff;
                  rsp_last_in_run  <= 1'b1;
                  rsp_last_of_map  <= hold_lom_ff;
                  hold_valid_ff    <= 1'b0;
                  state_ff         <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire
